### rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants for the thermistor converter
// Holds the resistance table (hundredths of an ohm) and fixed widths.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int ROM_SIZE     = 166;
    localparam int ROM_W        = 26;
    localparam int DIVIDER_OHMS = 3300;
    localparam int TEMP_OFFSET  = 40;
    localparam int CODE_W       = 12;
    localparam int TEMP_W       = 16;

    typedef logic [ROM_W-1:0] rom_word_t;

    function automatic rom_word_t ntc_rom(input logic [7:0] idx);
        rom_word_t v;
        case (idx)
            8'd0: v = 26'd40185972; 8'd1: v = 26'd37381023; 8'd2: v = 26'd34793261;
            8'd3: v = 26'd32404324; 8'd4: v = 26'd30197523; 8'd5: v = 26'd28157683;
            8'd6: v = 26'd26270996; 8'd7: v = 26'd24524887; 8'd8: v = 26'd22907896;
            8'd9: v = 26'd21409575; 8'd10: v = 26'd20020390; 8'd11: v = 26'd18731635;
            8'd12: v = 26'd17535357; 8'd13: v = 26'd16424282; 8'd14: v = 26'd15391757;
            8'd15: v = 26'd14431694; 8'd16: v = 26'd13538512; 8'd17: v = 26'd12707098;
            8'd18: v = 26'd11932764; 8'd19: v = 26'd11211205; 8'd20: v = 26'd10538469;
            8'd21: v = 26'd9910927; 8'd22: v = 26'd9325239; 8'd23: v = 26'd8778338;
            8'd24: v = 26'd8267395; 8'd25: v = 26'd7789811; 8'd26: v = 26'd7343186;
            8'd27: v = 26'd6925312; 8'd28: v = 26'd6534148; 8'd29: v = 26'd6167814;
            8'd30: v = 26'd5824571; 8'd31: v = 26'd5502816; 8'd32: v = 26'd5201063;
            8'd33: v = 26'd4917941; 8'd34: v = 26'd4652180; 8'd35: v = 26'd4402605;
            8'd36: v = 26'd4168125; 8'd37: v = 26'd3947734; 8'd38: v = 26'd3740494;
            8'd39: v = 26'd3545538; 8'd40: v = 26'd3362060; 8'd41: v = 26'd3189314;
            8'd42: v = 26'd3026603; 8'd43: v = 26'd2873284; 8'd44: v = 26'd2728754;
            8'd45: v = 26'd2592456; 8'd46: v = 26'd2463871; 8'd47: v = 26'd2342514;
            8'd48: v = 26'd2227934; 8'd49: v = 26'd2119713; 8'd50: v = 26'd2017458;
            8'd51: v = 26'd1920804; 8'd52: v = 26'd1829410; 8'd53: v = 26'd1742959;
            8'd54: v = 26'd1661153; 8'd55: v = 26'd1583715; 8'd56: v = 26'd1510385;
            8'd57: v = 26'd1440922; 8'd58: v = 26'd1375098; 8'd59: v = 26'd1312701;
            8'd60: v = 26'd1253533; 8'd61: v = 26'd1197406; 8'd62: v = 26'd1144148;
            8'd63: v = 26'd1093595; 8'd64: v = 26'd1045594; 8'd65: v = 26'd1000000;
            8'd66: v = 26'd956680; 8'd67: v = 26'd915506; 8'd68: v = 26'd876361;
            8'd69: v = 26'd839131; 8'd70: v = 26'd803714; 8'd71: v = 26'd770010;
            8'd72: v = 26'd737926; 8'd73: v = 26'd707376; 8'd74: v = 26'd678277;
            8'd75: v = 26'd650553; 8'd76: v = 26'd624130; 8'd77: v = 26'd598941;
            8'd78: v = 26'd574921; 8'd79: v = 26'd552008; 8'd80: v = 26'd530147;
            8'd81: v = 26'd509282; 8'd82: v = 26'd489363; 8'd83: v = 26'd470342;
            8'd84: v = 26'd452173; 8'd85: v = 26'd434814; 8'd86: v = 26'd418223;
            8'd87: v = 26'd402364; 8'd88: v = 26'd387199; 8'd89: v = 26'd372695;
            8'd90: v = 26'd358818; 8'd91: v = 26'd345539; 8'd92: v = 26'd332829;
            8'd93: v = 26'd320660; 8'd94: v = 26'd309007; 8'd95: v = 26'd297844;
            8'd96: v = 26'd287148; 8'd97: v = 26'd276898; 8'd98: v = 26'd267072;
            8'd99: v = 26'd257651; 8'd100: v = 26'd248616; 8'd101: v = 26'd239950;
            8'd102: v = 26'd231634; 8'd103: v = 26'd223653; 8'd104: v = 26'd215993;
            8'd105: v = 26'd208637; 8'd106: v = 26'd201574; 8'd107: v = 26'd194788;
            8'd108: v = 26'd188270; 8'd109: v = 26'd182005; 8'd110: v = 26'd175984;
            8'd111: v = 26'd170195; 8'd112: v = 26'd164628; 8'd113: v = 26'd159274;
            8'd114: v = 26'd154124; 8'd115: v = 26'd149168; 8'd116: v = 26'd144399;
            8'd117: v = 26'd139808; 8'd118: v = 26'd135388; 8'd119: v = 26'd131132;
            8'd120: v = 26'd127032; 8'd121: v = 26'd123083; 8'd122: v = 26'd119277;
            8'd123: v = 26'd115610; 8'd124: v = 26'd112075; 8'd125: v = 26'd108667;
            8'd126: v = 26'd105381; 8'd127: v = 26'd102211; 8'd128: v = 26'd99154;
            8'd129: v = 26'd96204; 8'd130: v = 26'd93358; 8'd131: v = 26'd90610;
            8'd132: v = 26'd87958; 8'd133: v = 26'd85398; 8'd134: v = 26'd82925;
            8'd135: v = 26'd80537; 8'd136: v = 26'd78230; 8'd137: v = 26'd76000;
            8'd138: v = 26'd73846; 8'd139: v = 26'd71765; 8'd140: v = 26'd69752;
            8'd141: v = 26'd67806; 8'd142: v = 26'd65925; 8'd143: v = 26'd64105;
            8'd144: v = 26'd62345; 8'd145: v = 26'd60642; 8'd146: v = 26'd58994;
            8'd147: v = 26'd57399; 8'd148: v = 26'd55855; 8'd149: v = 26'd54361;
            8'd150: v = 26'd52914; 8'd151: v = 26'd51513; 8'd152: v = 26'd50156;
            8'd153: v = 26'd48841; 8'd154: v = 26'd47568; 8'd155: v = 26'd46334;
            8'd156: v = 26'd45138; 8'd157: v = 26'd43979; 8'd158: v = 26'd42855;
            8'd159: v = 26'd41765; 8'd160: v = 26'd40709; 8'd161: v = 26'd39684;
            8'd162: v = 26'd38691; 8'd163: v = 26'd37726; 8'd164: v = 26'd36791;
            8'd165: v = 26'd35883;
            default: v = 26'd35883;
        endcase
        return v;
    endfunction

endpackage

### rtl/ntc_if.sv
// ----------------------------------------------------------------------------
// ntc_if: valid/ready channel
// Carries one request per valid and ready edge.
// ----------------------------------------------------------------------------
interface ntc_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_code;
    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface ntc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temp_q8;
    logic               clamped;
    modport source (output valid, output temp_q8, output clamped, input ready);
    modport sink   (input valid, input temp_q8, input clamped, output ready);
endinterface

### rtl/ntc_adc_to_temperature_top.sv
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_top: ADC code to temperature converter
// Resistance divide, table search, interpolation divide on one shared divider.
// ----------------------------------------------------------------------------
// The shared serial divider (36 bits wide up to FRAC_BITS = 10, one bit per
// cycle) runs both divides. A full-scale code skips the divides and goes
// straight from idle to the output state.
// One request at a time: in.ready is high only when idle.
// Asynchronous active-low reset returns the sequencer to idle, output empty.
module ntc_adc_to_temperature_top
    import ntc_pkg::*;
#(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int TABLE_ENTRIES  = 166,
    parameter int FRAC_BITS      = 8
)
(
    input logic       clk,
    input logic       rst_n,
    ntc_in_if.sink    in_ch,
    ntc_out_if.source out_ch
);
    // wide enough for the shifted interpolation numerator
    localparam int DW = (ROM_W + FRAC_BITS > 36) ? (ROM_W + FRAC_BITS) : 36;
    localparam int NE = (TABLE_ENTRIES < ROM_SIZE) ? ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES)
                                                  : ROM_SIZE;
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV1 = 3'd1, S_CLAMP = 3'd2,
                           S_SRCH = 3'd3, S_DIV2 = 3'd4, S_OUT = 3'd6;

    logic [2:0]      st_reg, st_next;
    logic [15:0]     code_reg;
    logic [DW-1:0]   r_reg;
    logic [7:0]      i_reg;
    logic            clamp_reg;
    logic [15:0]     temp_reg;
    logic            div_start;
    logic [DW-1:0]   div_num, div_den, div_quo;
    logic            div_done;
    rom_word_t       top_w, bot_w, e_i, e_i1;
    logic [DW-1:0]   r100;

    assign top_w = ntc_rom(8'd0);
    assign bot_w = ntc_rom(8'(NE - 1));
    assign e_i   = ntc_rom(i_reg);
    assign e_i1  = ntc_rom(i_reg + 8'd1);
    assign r100  = DW'(r_reg * 36'd100);

    ntc_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
    );

    always_comb
    begin
        div_start = 1'b0;
        div_num   = DW'(code_reg) * DW'(DIVIDER_OHMS);
        div_den   = DW'(ADC_FULL_SCALE) - DW'(code_reg);
        st_next   = st_reg;
        case (st_reg)
            S_IDLE:
                if (in_ch.valid)
                    st_next = S_DIV1;
            S_DIV1:
                if (div_done)
                    st_next = S_CLAMP;
            S_CLAMP:
                st_next = S_SRCH;
            S_SRCH:
                if (!(32'(i_reg) + 2 < NE && DW'(e_i1) > r_reg))
                begin
                    div_start = 1'b1;
                    div_num   = DW'(DW'(e_i) - r_reg) << FRAC_BITS;
                    div_den   = DW'(e_i) - DW'(e_i1);
                    st_next   = S_DIV2;
                end
            S_DIV2:
                if (div_done)
                    st_next = S_OUT;
            S_OUT:
                if (out_ch.ready)
                    st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
        if (st_reg == S_IDLE && in_ch.valid
            && !(32'(in_ch.adc_code) >= ADC_FULL_SCALE))
            div_start = 1'b1;
        if (st_reg == S_IDLE && in_ch.valid)
        begin
            div_num = DW'(in_ch.adc_code) * DW'(DIVIDER_OHMS);
            div_den = DW'(ADC_FULL_SCALE) - DW'(in_ch.adc_code);
            if (32'(in_ch.adc_code) >= ADC_FULL_SCALE)
                st_next = S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
                if (in_ch.valid)
                begin
                    code_reg  <= 16'(in_ch.adc_code);
                    i_reg     <= '0;
                    clamp_reg <= (32'(in_ch.adc_code) >= ADC_FULL_SCALE);
                    temp_reg  <= 16'(-(TEMP_OFFSET << FRAC_BITS));
                end
            S_DIV1:
                if (div_done)
                    r_reg <= div_quo;
            S_CLAMP:
            begin
                // clamp 100*R into table span
                if (r100 <= DW'(bot_w))
                begin
                    r_reg     <= DW'(bot_w);
                    clamp_reg <= 1'b1;
                end
                else if (r100 >= DW'(top_w))
                begin
                    r_reg     <= DW'(top_w);
                    clamp_reg <= 1'b1;
                end
                else
                    r_reg <= r100;
                if (DW'(bot_w) >= DW'(top_w))
                begin
                    r_reg     <= DW'(top_w);
                    clamp_reg <= 1'b1;
                end
            end
            S_SRCH:
                if (32'(i_reg) + 2 < NE && DW'(e_i1) > r_reg)
                    i_reg <= i_reg + 8'd1;
            S_DIV2:
                if (div_done)
                    temp_reg <= 16'((32'(i_reg) - TEMP_OFFSET) << FRAC_BITS)
                              + div_quo[15:0];
            default: ;
        endcase
    end

    assign in_ch.ready    = (st_reg == S_IDLE);
    assign out_ch.valid   = (st_reg == S_OUT);
    assign out_ch.temp_q8 = temp_reg;
    assign out_ch.clamped = clamp_reg;
endmodule

### rtl/ntc_div.sv
// ----------------------------------------------------------------------------
// ntc_div: shared restoring divider
// One quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ntc_div
    import ntc_pkg::*;
#(
    parameter int W = 36
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[W-1]};
        trial     = shifted - {1'b0, d_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            q_next    = num;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            d_reg <= den;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quo  = q_next;
endmodule
